@@ hdl/qmj_pkg.sv @@
// Shared types and constants for the quintic minimum-jerk interpolator.
// No dependencies; every other file of the block imports this package.
package qmj_pkg;

  localparam int QMJ_QDEPTH = 4;
  localparam logic [15:0] QMJ_DUR_RESET = 16'd1000;

  // Divider geometry: a 46-bit dividend covers elapsed << 30.
  localparam int NUM_W     = 46;
  localparam int DEN_W     = 32;
  localparam int DIV_BITS  = 2;
  localparam int DIV_ITERS = NUM_W / DIV_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_ITERS + 1);

  typedef enum logic [1:0] {
    KIND_NODUR,
    KIND_START,
    KIND_END,
    KIND_MOVE
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] start;
    logic signed [15:0] target;
    logic        [15:0] elapsed;
    logic        [15:0] mag;
    logic               dneg;
  } item_t;

  typedef struct packed {
    logic [15:0] angle;
    logic [23:0] velocity;
    logic [31:0] acceleration;
    logic        finished;
    logic        valid_res;
    logic        saturated;
  } res_t;

  typedef struct packed {
    logic             go;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_DIVU,
    B_UU,
    B_U3,
    B_POS,
    B_S,
    B_SS,
    B_SL,
    B_OFF,
    B_PV,
    B_Q,
    B_D2,
    B_DIVV,
    B_DIVA,
    B_OUT
  } back_state_t;

endpackage

@@ hdl/qmj_front.sv @@
// Front end: takes requests from the input channel and classifies them.
// Depends on qmj_pkg for the item and kind types.
module qmj_front import qmj_pkg::*; (
  input  logic               push,
  input  logic               q_full,
  input  logic signed [15:0] in_start_angle,
  input  logic signed [15:0] in_target_angle,
  input  logic        [15:0] in_elapsed_ms,
  input  logic        [15:0] dur,
  output logic               q_wr,
  output item_t              q_item
);

  logic signed [16:0] delta;

  always_comb begin
    delta = 17'(in_target_angle) - 17'(in_start_angle);
    q_wr  = push && !q_full;
    q_item.start   = in_start_angle;
    q_item.target  = in_target_angle;
    q_item.elapsed = in_elapsed_ms;
    q_item.dneg    = delta[16];
    q_item.mag     = delta[16] ? 16'(-delta) : delta[15:0];
    if (dur == 16'd0) begin
      q_item.kind = KIND_NODUR;
    end else if (in_elapsed_ms == 16'd0) begin
      q_item.kind = KIND_START;
    end else if (in_elapsed_ms >= dur) begin
      q_item.kind = KIND_END;
    end else begin
      q_item.kind = KIND_MOVE;
    end
  end

endmodule

@@ hdl/qmj_fifo.sv @@
// Short request queue between the front end and the back end.
// Depends on qmj_pkg for the item type.
module qmj_fifo import qmj_pkg::*; #(
  parameter int DEPTH = QMJ_QDEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_en,
  input  item_t wr_data,
  input  logic  rd_en,
  output item_t rd_data,
  output logic  full,
  output logic  empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

@@ hdl/qmj_div.sv @@
// Iterative restoring divider, two quotient bits per cycle.
// Depends on qmj_pkg for widths and the request/response structs.
module qmj_div import qmj_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy_r, done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0]     rem_r, den_r, rem_nxt;
  logic [NUM_W-1:0]     num_r, num_nxt;

  always_comb begin
    logic [DEN_W-1:0] r;
    logic [NUM_W-1:0] n;
    logic [DEN_W:0]   t;
    r = rem_r;
    n = num_r;
    t = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      t = {r, n[NUM_W-1]};
      n = {n[NUM_W-2:0], 1'b0};
      if (t >= {1'b0, den_r}) begin
        t    = t - {1'b0, den_r};
        n[0] = 1'b1;
      end
      r = t[DEN_W-1:0];
    end
    rem_nxt = r;
    num_nxt = n;
  end

  assign rsp.done = done_r;
  assign rsp.quot = num_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_ITERS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      num_r <= req.num;
      den_r <= req.den;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule

@@ hdl/qmj_back.sv @@
// Back end: evaluates the quintic profile with one shared multiplier and
// the shared divider, then saturates into the result register. Uses qmj_pkg.
module qmj_back import qmj_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] dur,
  input  item_t       q_data,
  input  logic        q_empty,
  output logic        q_pop,
  output div_req_t    div_req,
  input  div_rsp_t    div_rsp,
  input  logic        res_pop,
  output res_t        res,
  output logic        res_full
);

  localparam logic [30:0] ONE31 = 31'h4000_0000;

  back_state_t state_r, state_nxt;
  item_t       item_r;
  res_t        res_r, res_nxt;
  logic        full_r, res_wr, slot_free;

  logic [29:0] u_r, w_r, lin_r, u2_r, u3_r;
  logic        aneg_r;
  logic [33:0] inner_r, apoly_r;
  logic [30:0] pos_r, vpoly_r;
  logic [28:0] s_r;
  logic [16:0] off_r;
  logic [46:0] pv_r;
  logic [49:0] q_r;
  logic [26:0] vnum_r, vmag_r;
  logic [31:0] d2_r;
  logic [43:0] anum_r, amag_r;

  logic [33:0] mul_a;
  logic [30:0] mul_b;
  logic [64:0] prod;
  logic [30:0] tu, lin_c, w_c;
  logic [35:0] inner_c;
  logic [26:0] ss;
  logic [28:0] sl;
  logic [56:0] pvk;
  logic [63:0] qk;

  assign prod      = 65'(mul_a) * 65'(mul_b);
  assign slot_free = !full_r || res_pop;
  assign res       = res_r;
  assign res_full  = full_r;

  // Small arithmetic around the multiplier.
  always_comb begin
    tu      = {u_r, 1'b0};
    lin_c   = (tu > ONE31) ? tu - ONE31 : ONE31 - tu;
    w_c     = ONE31 - {1'b0, u_r};
    inner_c = 36'({u2_r, 2'b0}) + 36'({u2_r, 1'b0}) + (36'd10 << 30)
            - (36'({u_r, 4'b0}) - 36'(u_r));
    ss      = prod[56:30];
    sl      = prod[58:30];
    pvk     = 57'({pv_r, 10'b0}) - 57'({pv_r, 4'b0}) - 57'({pv_r, 3'b0});
    qk      = 64'({q_r, 14'b0}) - 64'({q_r, 10'b0}) + 64'({q_r, 8'b0})
            + 64'({q_r, 3'b0}) + 64'(q_r);
  end

  always_comb begin
    logic [18:0] asum;
    logic [23:0] vm;
    logic [31:0] am;
    logic        sat, an;
    asum = '0;
    vm   = '0;
    am   = '0;
    sat  = 1'b0;
    an   = 1'b0;
    state_nxt = state_r;
    q_pop     = 1'b0;
    res_wr    = 1'b0;
    res_nxt   = '0;
    div_req   = '0;
    mul_a     = '0;
    mul_b     = '0;
    case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          if (q_data.kind == KIND_MOVE) begin
            q_pop       = 1'b1;
            div_req.go  = 1'b1;
            div_req.num = {q_data.elapsed, 30'b0};
            div_req.den = DEN_W'(dur);
            state_nxt   = B_DIVU;
          end else if (slot_free) begin
            q_pop  = 1'b1;
            res_wr = 1'b1;
            case (q_data.kind)
              KIND_START: begin
                res_nxt.angle     = q_data.start;
                res_nxt.valid_res = 1'b1;
              end
              KIND_END: begin
                res_nxt.angle     = q_data.target;
                res_nxt.finished  = 1'b1;
                res_nxt.valid_res = 1'b1;
              end
              default: begin
                res_nxt = '0;
              end
            endcase
          end
        end
      end
      B_DIVU: begin
        if (div_rsp.done) begin
          state_nxt = B_UU;
        end
      end
      B_UU: begin
        mul_a = 34'(u_r);
        mul_b = 31'(u_r);
        state_nxt = B_U3;
      end
      B_U3: begin
        mul_a = 34'(u2_r);
        mul_b = 31'(u_r);
        state_nxt = B_POS;
      end
      B_POS: begin
        mul_a = inner_r;
        mul_b = 31'(u3_r);
        state_nxt = B_S;
      end
      B_S: begin
        mul_a = 34'(u_r);
        mul_b = 31'(w_r);
        state_nxt = B_SS;
      end
      B_SS: begin
        mul_a = 34'(s_r);
        mul_b = 31'(s_r);
        state_nxt = B_SL;
      end
      B_SL: begin
        mul_a = 34'(s_r);
        mul_b = 31'(lin_r);
        state_nxt = B_OFF;
      end
      B_OFF: begin
        mul_a = 34'(pos_r);
        mul_b = 31'(item_r.mag);
        state_nxt = B_PV;
      end
      B_PV: begin
        mul_a = 34'(vpoly_r);
        mul_b = 31'(item_r.mag);
        state_nxt = B_Q;
      end
      B_Q: begin
        mul_a = apoly_r;
        mul_b = 31'(item_r.mag);
        state_nxt = B_D2;
      end
      B_D2: begin
        mul_a       = 34'(dur);
        mul_b       = 31'(dur);
        div_req.go  = 1'b1;
        div_req.num = NUM_W'(vnum_r);
        div_req.den = DEN_W'(dur);
        state_nxt   = B_DIVV;
      end
      B_DIVV: begin
        if (div_rsp.done) begin
          div_req.go  = 1'b1;
          div_req.num = NUM_W'(anum_r);
          div_req.den = d2_r;
          state_nxt   = B_DIVA;
        end
      end
      B_DIVA: begin
        if (div_rsp.done) begin
          state_nxt = B_OUT;
        end
      end
      B_OUT: begin
        if (slot_free) begin
          res_wr = 1'b1;
          // Angle: start plus the signed offset, clamped to Q4.12.
          asum = 19'(item_r.start) + (item_r.dneg ? 19'(0) - 19'(off_r) : 19'(off_r));
          if ($signed(asum) > 19'sd32767) begin
            res_nxt.angle = 16'h7FFF;
            sat = 1'b1;
          end else if ($signed(asum) < -19'sd32768) begin
            res_nxt.angle = 16'h8000;
            sat = 1'b1;
          end else begin
            res_nxt.angle = asum[15:0];
          end
          // Velocity carries the sign of the angle change.
          if (item_r.dneg) begin
            if (vmag_r > 27'd8388608) begin
              vm  = 24'h80_0000;
              sat = 1'b1;
            end else begin
              vm = vmag_r[23:0];
            end
            res_nxt.velocity = 24'd0 - vm;
          end else begin
            if (vmag_r > 27'd8388607) begin
              vm  = 24'h7F_FFFF;
              sat = 1'b1;
            end else begin
              vm = vmag_r[23:0];
            end
            res_nxt.velocity = vm;
          end
          // Acceleration flips sign past the midpoint; zero stays positive.
          an = (item_r.dneg != aneg_r) && (amag_r != '0);
          if (an) begin
            if (amag_r > 44'h0_8000_0000) begin
              am  = 32'h8000_0000;
              sat = 1'b1;
            end else begin
              am = amag_r[31:0];
            end
            res_nxt.acceleration = 32'd0 - am;
          end else begin
            if (amag_r > 44'h0_7FFF_FFFF) begin
              am  = 32'h7FFF_FFFF;
              sat = 1'b1;
            end else begin
              am = amag_r[31:0];
            end
            res_nxt.acceleration = am;
          end
          res_nxt.finished  = 1'b0;
          res_nxt.valid_res = 1'b1;
          res_nxt.saturated = sat;
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      full_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (res_wr) begin
        full_r <= 1'b1;
      end else if (res_pop) begin
        full_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_wr) begin
      res_r <= res_nxt;
    end
    if (state_r == B_IDLE && q_pop) begin
      item_r <= q_data;
    end
    case (state_r)
      B_DIVU: begin
        if (div_rsp.done) begin
          u_r <= div_rsp.quot[29:0];
        end
      end
      B_UU: begin
        u2_r   <= prod[59:30];
        w_r    <= w_c[29:0];
        lin_r  <= lin_c[29:0];
        aneg_r <= (tu > ONE31);
      end
      B_U3: begin
        u3_r    <= prod[59:30];
        inner_r <= inner_c[33:0];
      end
      B_POS: begin
        pos_r <= prod[60:30];
      end
      B_S: begin
        s_r <= prod[58:30];
      end
      B_SS: begin
        vpoly_r <= 31'({ss, 5'b0}) - 31'({ss, 1'b0});
      end
      B_SL: begin
        apoly_r <= 34'({sl, 6'b0}) - 34'({sl, 2'b0});
      end
      B_OFF: begin
        off_r <= prod[46:30];
      end
      B_PV: begin
        pv_r <= prod[46:0];
      end
      B_Q: begin
        q_r    <= prod[49:0];
        vnum_r <= pvk[56:30];
      end
      B_D2: begin
        d2_r   <= prod[31:0];
        anum_r <= qk[63:20];
      end
      B_DIVV: begin
        if (div_rsp.done) begin
          vmag_r <= div_rsp.quot[26:0];
        end
      end
      B_DIVA: begin
        if (div_rsp.done) begin
          amag_r <= div_rsp.quot[43:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ hdl/quintic_min_jerk_interpolator_unit.sv @@
// Top level of the quintic minimum-jerk interpolator.
// Depends on qmj_pkg, qmj_front, qmj_fifo, qmj_div and qmj_back.
//
//   Channel   Handshake          Payload
//   -------   ----------------   -------------------------------------------
//   input     push / full        in_start_angle, in_target_angle, in_elapsed_ms
//   result    empty / pop        out_angle, out_velocity, out_acceleration,
//                                out_finished, out_valid_res, out_saturated
//   config    cfg_wr_en          cfg_wr_data (duration in ms)
//
// A request at rest (zero duration, zero elapsed time, or elapsed at or past
// the duration) is answered straight from the idle state. A moving request
// makes three passes through the shared divider at two quotient bits per
// cycle plus ten shared multiplier steps in the back end.
// Reset is synchronous and active low; it empties the queues and sets the
// duration to 1000 ms. The front end keeps taking requests into its queue
// while the back end works or while a result waits to be popped.
module quintic_min_jerk_interpolator_unit import qmj_pkg::*; #(
  parameter int QDEPTH = QMJ_QDEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] in_start_angle,
  input  logic signed [15:0] in_target_angle,
  input  logic        [15:0] in_elapsed_ms,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] out_angle,
  output logic signed [23:0] out_velocity,
  output logic signed [31:0] out_acceleration,
  output logic               out_finished,
  output logic               out_valid_res,
  output logic               out_saturated,
  input  logic               cfg_wr_en,
  input  logic        [15:0] cfg_wr_data
);

  // The duration register; the user must change it only while the block is idle (not enforced).
  logic [15:0] dur_r;

  logic     q_wr, q_pop, q_full, q_empty, res_full;
  item_t    q_item, q_head;
  div_req_t div_req;
  div_rsp_t div_rsp;
  res_t     res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dur_r <= QMJ_DUR_RESET;
    end else if (cfg_wr_en) begin
      dur_r <= cfg_wr_data;
    end
  end

  // The front end classifies each request before it is queued, so the
  // back end only has to run the full arithmetic for moving requests.
  qmj_front u_front (
    .push            (push),
    .q_full          (q_full),
    .in_start_angle  (in_start_angle),
    .in_target_angle (in_target_angle),
    .in_elapsed_ms   (in_elapsed_ms),
    .dur             (dur_r),
    .q_wr            (q_wr),
    .q_item          (q_item)
  );

  qmj_fifo #(.DEPTH(QDEPTH)) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_data (q_item),
    .rd_en   (q_pop),
    .rd_data (q_head),
    .full    (q_full),
    .empty   (q_empty)
  );

  qmj_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // The back end owns the single result register that feeds the result
  // channel; a new result is written as soon as the old one is popped.
  qmj_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .dur      (dur_r),
    .q_data   (q_head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .div_req  (div_req),
    .div_rsp  (div_rsp),
    .res_pop  (pop),
    .res      (res),
    .res_full (res_full)
  );

  assign full             = q_full;
  assign empty            = !res_full;
  assign out_angle        = res.angle;
  assign out_velocity     = res.velocity;
  assign out_acceleration = res.acceleration;
  assign out_finished     = res.finished;
  assign out_valid_res    = res.valid_res;
  assign out_saturated    = res.saturated;

endmodule

@@ sim/quintic_min_jerk_interpolator_unit_test.sv @@
// Self-checking testbench for quintic_min_jerk_interpolator_unit.
// Depends on qmj_pkg and the block; random stimulus, an in-bench motion predictor.
module quintic_min_jerk_interpolator_unit_test;
  import qmj_pkg::*;

  localparam longint unsigned ONE_Q30 = 64'd1 << 30;
  localparam longint unsigned ACC_SCALE = 64'd16000000;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    logic signed [15:0] start;
    logic signed [15:0] target;
    logic        [15:0] elapsed;
  } joint_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  logic signed [15:0] in_start_angle = '0;
  logic signed [15:0] in_target_angle = '0;
  logic        [15:0] in_elapsed_ms = '0;
  logic empty;
  logic pop = 1'b0;
  logic signed [15:0] out_angle;
  logic signed [23:0] out_velocity;
  logic signed [31:0] out_acceleration;
  logic out_finished, out_valid_res, out_saturated;
  logic cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  joint_req_t pending_reqs[$];
  res_t       expected_motion[$];
  logic [15:0] duration_ms = QMJ_DUR_RESET;
  int  error_count = 0;
  int  send_gap = 0;
  int  pop_gap = 0;
  int  idle_cycles = 0;

  quintic_min_jerk_interpolator_unit i_dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_start_angle(in_start_angle), .in_target_angle(in_target_angle),
    .in_elapsed_ms(in_elapsed_ms), .empty(empty), .pop(pop),
    .out_angle(out_angle), .out_velocity(out_velocity),
    .out_acceleration(out_acceleration), .out_finished(out_finished),
    .out_valid_res(out_valid_res), .out_saturated(out_saturated),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Gap lengths: mostly back to back, sometimes a few cycles, rarely a long pause.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Signs a truncated magnitude and clamps it to a signed field of the given width.
  function automatic longint clamp_signed(longint unsigned mag, bit neg, int w,
                                          inout bit sat);
    longint unsigned maxpos;
    maxpos = (64'd1 << (w - 1)) - 1;
    if (neg) begin
      if (mag > maxpos + 1) begin
        sat = 1'b1;
        mag = maxpos + 1;
      end
      return -longint'(mag);
    end
    if (mag > maxpos) begin
      sat = 1'b1;
      mag = maxpos;
    end
    return longint'(mag);
  endfunction

  // Angle, velocity and acceleration of one joint on the minimum-jerk profile.
  function automatic res_t predict_motion(joint_req_t r, logic [15:0] dur);
    res_t res;
    longint st, tg, delta, ang, vel, acc;
    longint unsigned mag, e, d, u, w, u2, u3, inner, pos, s, vpoly, two_u, lin, apoly;
    longint unsigned off, vmag, amag, q, qh, ql, d2, qa, ra;
    bit dneg, aneg, sat;
    st = r.start;
    tg = r.target;
    e = r.elapsed;
    d = dur;
    ang = 0;
    vel = 0;
    acc = 0;
    sat = 1'b0;
    res = '0;
    res.valid_res = 1'b1;
    if (d == 0) begin
      res.valid_res = 1'b0;
    end else if (e == 0) begin
      ang = st;
    end else if (e >= d) begin
      ang = tg;
      res.finished = 1'b1;
    end else begin
      delta = tg - st;
      dneg = delta < 0;
      mag = dneg ? -delta : delta;
      u = (e << 30) / d;
      w = ONE_Q30 - u;
      u2 = (u * u) >> 30;
      u3 = (u2 * u) >> 30;
      inner = 6 * u2 + 10 * ONE_Q30 - 15 * u;
      pos = (u3 * inner) >> 30;
      s = (u * w) >> 30;
      vpoly = 30 * ((s * s) >> 30);
      two_u = 2 * u;
      aneg = two_u > ONE_Q30;
      lin = aneg ? two_u - ONE_Q30 : ONE_Q30 - two_u;
      apoly = 60 * ((s * lin) >> 30);
      off = (mag * pos) >> 30;
      ang = dneg ? st - longint'(off) : st + longint'(off);
      if (ang > 32767) begin
        ang = 32767;
        sat = 1'b1;
      end
      if (ang < -32768) begin
        ang = -32768;
        sat = 1'b1;
      end
      vmag = (mag * vpoly * 1000) / (d << 30);
      vel = clamp_signed(vmag, dneg, 24, sat);
      q = mag * apoly;
      qh = q >> 30;
      ql = q & (ONE_Q30 - 1);
      d2 = d * d;
      qa = (qh * ACC_SCALE) / d2;
      ra = (qh * ACC_SCALE) % d2;
      amag = qa + ((ra << 30) + ql * ACC_SCALE) / (d2 << 30);
      acc = clamp_signed(amag, (dneg != aneg) && amag != 0, 32, sat);
    end
    res.angle = ang[15:0];
    res.velocity = vel[23:0];
    res.acceleration = acc[31:0];
    res.saturated = sat;
    return res;
  endfunction

  // Driver: holds a request until it is taken, predicts its result on acceptance.
  always @(posedge clk) begin
    joint_req_t nxt;
    logic taken;
    if (rst_n) begin
      taken = push && !full;
      if (taken) begin
        nxt.start = in_start_angle;
        nxt.target = in_target_angle;
        nxt.elapsed = in_elapsed_ms;
        expected_motion.push_back(predict_motion(nxt, duration_ms));
        send_gap = pick_gap();
      end
      if (!push || taken) begin
        if (send_gap > 0) begin
          send_gap--;
          push <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          nxt = pending_reqs.pop_front();
          in_start_angle <= nxt.start;
          in_target_angle <= nxt.target;
          in_elapsed_ms <= nxt.elapsed;
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: random pop gaps; each popped result is checked against the oldest prediction.
  always @(posedge clk) begin
    res_t exp_res;
    if (rst_n) begin
      if (pop && !empty) begin
        pop_gap = pick_gap();
        if (expected_motion.size() == 0) begin
          $error("result popped with no request outstanding");
          error_count++;
        end else begin
          exp_res = expected_motion.pop_front();
          if (out_angle !== exp_res.angle) begin
            $error("angle: expected %0d, got %0d", $signed(exp_res.angle), out_angle);
            error_count++;
          end
          if (out_velocity !== exp_res.velocity) begin
            $error("velocity: expected %0d, got %0d", $signed(exp_res.velocity),
                   out_velocity);
            error_count++;
          end
          if (out_acceleration !== exp_res.acceleration) begin
            $error("acceleration: expected %0d, got %0d", $signed(exp_res.acceleration),
                   out_acceleration);
            error_count++;
          end
          if (out_finished !== exp_res.finished) begin
            $error("finished: expected %0b, got %0b", exp_res.finished, out_finished);
            error_count++;
          end
          if (out_valid_res !== exp_res.valid_res) begin
            $error("valid_res: expected %0b, got %0b", exp_res.valid_res, out_valid_res);
            error_count++;
          end
          if (out_saturated !== exp_res.saturated) begin
            $error("saturated: expected %0b, got %0b", exp_res.saturated, out_saturated);
            error_count++;
          end
        end
      end
      if (pop_gap > 0) begin
        pop_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog: a hung handshake ends the run.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty) || cfg_wr_en) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic queue_req(int st, int tg, int el);
    joint_req_t r;
    r.start = 16'(st);
    r.target = 16'(tg);
    r.elapsed = 16'(el);
    pending_reqs.push_back(r);
  endtask

  // Random joint request; elapsed is biased into the moving part of the profile.
  task automatic queue_random_req();
    int st, tg, el, roll;
    roll = $urandom_range(9);
    st = (roll == 0) ? -32768 : (roll == 1) ? 32767 : int'($urandom_range(65535)) - 32768;
    roll = $urandom_range(9);
    tg = (roll == 0) ? -32768 : (roll == 1) ? 32767 : int'($urandom_range(65535)) - 32768;
    roll = $urandom_range(99);
    if (roll < 5) el = 0;
    else if (roll < 12) el = (duration_ms == 0) ? 0 : $urandom_range(65535, duration_ms);
    else if (roll < 20) el = $urandom_range(65535);
    else if (duration_ms > 1) el = $urandom_range(duration_ms - 1, 1);
    else el = $urandom_range(65535);
    queue_req(st, tg, el);
  endtask

  // Lets the queue drain and every result come back, so the block is idle.
  task automatic drain();
    while (pending_reqs.size() > 0 || push || expected_motion.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_duration(logic [15:0] dur);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= dur;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    duration_ms = dur;
    @(posedge clk);
  endtask

  initial begin
    logic [15:0] phase_dur[10];
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests at the reset duration of 1000 ms.
    queue_req(-32768, 32767, 500);
    queue_req(32767, -32768, 500);
    queue_req(-32768, 32767, 0);
    queue_req(100, -200, 1000);
    queue_req(100, -200, 65535);
    queue_req(0, 4096, 1);
    queue_req(0, 4096, 999);
    queue_req(32767, -32768, 250);
    queue_req(-32768, 32767, 750);
    queue_req(1234, 1234, 400);
    queue_req(-5, 5, 10);
    drain();

    // Zero duration makes every result invalid.
    write_duration(16'd0);
    queue_req(-32768, 32767, 0);
    queue_req(32767, -32768, 65535);
    queue_req(1, 2, 3);
    drain();
    // Very short durations drive velocity and acceleration into saturation.
    write_duration(16'd2);
    queue_req(-32768, 32767, 1);
    queue_req(32767, -32768, 1);
    queue_req(0, 1, 1);
    drain();
    write_duration(16'd65535);
    queue_req(-32768, 32767, 65534);
    queue_req(32767, -32768, 32768);
    queue_req(0, 0, 16'hAAAA);
    queue_req(-1, 1, 16'h5555);
    drain();

    phase_dur = '{16'd1000, 16'd1, 16'd3, 16'd65535, 16'd7, 16'd0, 16'd2,
                  16'd40, 16'd0, 16'd5000};
    phase_dur[8] = 16'($urandom_range(65535, 1));
    for (int p = 0; p < 10; p++) begin
      write_duration(phase_dur[p]);
      for (int i = 0; i < 105; i++) queue_random_req();
      drain();
    end

    repeat (100) @(posedge clk);
    if (error_count == 0 && expected_motion.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
